### design/assert_macros.svh
// Assertion macros shared by the checker files.
// Self-contained; no other includes.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on a plain property, masked during reset.
`define MMC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent check that a condition implies another in the next cycle.
`define MMC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/mmc_pkg.sv
// Package for the magnetometer min/max calibrator: beat types, codes, constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mmc_pkg;

  localparam int SAMPLE_LIMIT_DEF = 1000;
  localparam int CNT_W            = 10;
  localparam int COUNT_CAP        = 1023;
  localparam int AXES             = 3;
  localparam int SCALE_W          = 25;
  localparam int DIV_STEPS        = 25;
  localparam int PROD_W           = 17 + SCALE_W + 1;
  localparam int FRAC_SHIFT       = 9;
  localparam logic [SCALE_W-1:0] UNITY_SCALE = SCALE_W'(1) << (SCALE_W - 1);

  typedef enum logic [1:0] {
    REQ_START  = 2'd0,
    REQ_SAMPLE = 2'd1,
    REQ_FINISH = 2'd2,
    REQ_APPLY  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV_LOAD,
    ST_DIV_STEP,
    ST_MUL,
    ST_SAT,
    ST_DONE
  } state_t;

  typedef struct packed {
    req_t               req_type;
    logic signed [15:0] in_x;
    logic signed [15:0] in_y;
    logic signed [15:0] in_z;
  } item_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic               is_calibrated;
    logic [CNT_W-1:0]   samples_taken;
    logic               saturated;
  } result_t;

endpackage

`default_nettype wire

### design/magnetometer_minmax_calibrator.sv
// Magnetometer min/max hard/soft-iron calibrator, top level.
// Depends on mmc_pkg.
// Usage:
//   item channel (item_valid/item_ready/item) carries one request beat:
//   start, sample, finish or apply, with a raw X/Y/Z sample.
//   result channel (result_valid/result_ready/result) returns exactly one
//   beat per request: corrected (or raw) axes for apply, zeros otherwise,
//   plus the calibrated flag, sample count and a clamp flag.
// Sequence from accept to result valid, through the output register:
//   start, sample, uncalibrated apply: exec state, then done state.
//   calibrated apply: exec, then mul and sat states per axis (one shared multiplier).
//   finish: exec, then per axis a div-load state and, for a non-zero range,
//   div-step states (one shared restoring divider, one bit a cycle), then done.
// One request in flight; item_ready is high only when idle, so a new beat
//   is taken only after the previous request has left its done state, and
//   a new beat is taken while the previous result still waits.
// A stalled result holds in the output register; a finished request then
//   waits in its done state until the register frees.
// Reset (rst, synchronous) clears trackers, count, offsets, flag and sets
//   every scale to unity.
`timescale 1ns / 1ps
`default_nettype none

module magnetometer_minmax_calibrator
  import mmc_pkg::*;
#(
  parameter int SAMPLE_LIMIT = SAMPLE_LIMIT_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_ready,
  input  wire item_t   item,
  output logic         result_valid,
  input  wire logic    result_ready,
  output result_t      result
);

  localparam int LimitEff = (SAMPLE_LIMIT < COUNT_CAP) ? SAMPLE_LIMIT : COUNT_CAP;

  state_t state, state_next;

  item_t                     req;
  logic [1:0]                axis;
  logic                      axis_last;
  logic signed [15:0]        axis_min    [AXES];
  logic signed [15:0]        axis_max    [AXES];
  logic signed [15:0]        axis_offset [AXES];
  logic [SCALE_W-1:0]        axis_scale  [AXES];
  logic signed [15:0]        corr        [AXES];
  logic                      clamped;
  logic [CNT_W-1:0]          sample_counter;
  logic                      calibrated_flag;

  logic [4:0]                bit_cnt;
  logic [15:0]               rem;
  logic [15:0]               divisor;
  logic [SCALE_W-2:0]        quo;
  logic signed [PROD_W-1:0]  prod;

  // control
  logic do_exec, div_load, div_step, div_done, mul_en, sat_en, out_load;

  // datapath
  logic signed [15:0] sel_min, sel_max, sel_off, sel_in;
  logic [SCALE_W-1:0] sel_scale;
  logic signed [16:0] ext_sum, ext_rng, diff_a;
  logic [15:0]        range_u;
  logic               dbit, ge;
  logic [16:0]        shifted, sub;
  logic [SCALE_W-1:0] quo_full;
  logic signed [25:0] scl_s;
  logic signed [PROD_W-FRAC_SHIFT-1:0] q;
  logic               q_ovf;
  logic signed [15:0] q_sat;
  logic               sample_ok;

  assign axis_last = (axis == 2'd2);
  assign sel_min   = axis_min[axis];
  assign sel_max   = axis_max[axis];
  assign sel_off   = axis_offset[axis];
  assign sel_scale = axis_scale[axis];

  always_comb begin
    case (axis)
      2'd0:    sel_in = req.in_x;
      2'd1:    sel_in = req.in_y;
      default: sel_in = req.in_z;
    endcase
  end

  assign ext_sum = {sel_max[15], sel_max} + {sel_min[15], sel_min};
  assign ext_rng = {sel_max[15], sel_max} - {sel_min[15], sel_min};
  assign range_u = ext_rng[15:0];

  assign dbit     = (bit_cnt == 5'(DIV_STEPS - 1));
  assign shifted  = {rem, dbit};
  assign ge       = (shifted >= {1'b0, divisor});
  assign sub      = shifted - {1'b0, divisor};
  assign quo_full = {quo, ge};

  assign diff_a = {sel_in[15], sel_in} - {sel_off[15], sel_off};
  assign scl_s  = $signed({1'b0, sel_scale});

  assign q     = prod[PROD_W-1:FRAC_SHIFT];
  assign q_ovf = !((&q[$high(q):15]) || !(|q[$high(q):15]));
  always_comb begin
    if (!q_ovf) begin
      q_sat = q[15:0];
    end else if (q[$high(q)]) begin
      q_sat = 16'sh8000;
    end else begin
      q_sat = 16'sh7FFF;
    end
  end

  assign sample_ok = (sample_counter < CNT_W'(LimitEff));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (item_valid) state_next = ST_EXEC;
      ST_EXEC: begin
        case (req.req_type)
          REQ_FINISH: state_next = ST_DIV_LOAD;
          REQ_APPLY:  state_next = calibrated_flag ? ST_MUL : ST_DONE;
          default:    state_next = ST_DONE;
        endcase
      end
      ST_DIV_LOAD: begin
        if (range_u != 16'd0) state_next = ST_DIV_STEP;
        else if (axis_last)   state_next = ST_DONE;
      end
      ST_DIV_STEP: begin
        if (bit_cnt == 5'd0) state_next = axis_last ? ST_DONE : ST_DIV_LOAD;
      end
      ST_MUL:      state_next = ST_SAT;
      ST_SAT:      state_next = axis_last ? ST_DONE : ST_MUL;
      ST_DONE:     if (!result_valid || result_ready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    item_ready = 1'b0;
    do_exec    = 1'b0;
    div_load   = 1'b0;
    div_step   = 1'b0;
    div_done   = 1'b0;
    mul_en     = 1'b0;
    sat_en     = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE:     item_ready = 1'b1;
      ST_EXEC:     do_exec    = 1'b1;
      ST_DIV_LOAD: div_load   = 1'b1;
      ST_DIV_STEP: begin
        div_step = 1'b1;
        div_done = (bit_cnt == 5'd0);
      end
      ST_MUL:      mul_en     = 1'b1;
      ST_SAT:      sat_en     = 1'b1;
      ST_DONE:     out_load   = !result_valid || result_ready;
      default:     ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      req <= item;
    end
  end

  // trackers, offsets, scales, flag
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_counter  <= '0;
      calibrated_flag <= 1'b0;
      for (int i = 0; i < AXES; i++) begin
        axis_min[i]    <= '0;
        axis_max[i]    <= '0;
        axis_offset[i] <= '0;
        axis_scale[i]  <= UNITY_SCALE;
      end
    end else begin
      if (do_exec) begin
        case (req.req_type)
          REQ_START: begin
            calibrated_flag <= 1'b0;
            sample_counter  <= '0;
            for (int i = 0; i < AXES; i++) begin
              axis_min[i] <= '0;
              axis_max[i] <= '0;
            end
          end
          REQ_SAMPLE: begin
            if (sample_ok) begin
              sample_counter <= sample_counter + CNT_W'(1);
              if (sample_counter == '0) begin
                axis_min[0] <= req.in_x; axis_max[0] <= req.in_x;
                axis_min[1] <= req.in_y; axis_max[1] <= req.in_y;
                axis_min[2] <= req.in_z; axis_max[2] <= req.in_z;
              end else begin
                if (req.in_x < axis_min[0]) axis_min[0] <= req.in_x;
                if (req.in_x > axis_max[0]) axis_max[0] <= req.in_x;
                if (req.in_y < axis_min[1]) axis_min[1] <= req.in_y;
                if (req.in_y > axis_max[1]) axis_max[1] <= req.in_y;
                if (req.in_z < axis_min[2]) axis_min[2] <= req.in_z;
                if (req.in_z > axis_max[2]) axis_max[2] <= req.in_z;
              end
            end
          end
          REQ_FINISH: calibrated_flag <= 1'b1;
          default:    ;
        endcase
      end
      if (div_load) begin
        axis_offset[axis] <= ext_sum[16:1];
        if (range_u == 16'd0) begin
          axis_scale[axis] <= UNITY_SCALE;
        end
      end
      if (div_done) begin
        axis_scale[axis] <= quo_full;
      end
    end
  end

  // sequencer counters and shared divider / multiplier
  always_ff @(posedge clk) begin
    if (rst) begin
      axis <= '0;
    end else if (do_exec) begin
      axis <= '0;
    end else if ((div_load && range_u == 16'd0) || div_done || sat_en) begin
      axis <= axis_last ? 2'd0 : axis + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (div_load) begin
      divisor <= range_u;
      rem     <= '0;
      quo     <= '0;
      bit_cnt <= 5'(DIV_STEPS - 1);
    end else if (div_step) begin
      rem     <= ge ? sub[15:0] : shifted[15:0];
      quo     <= quo_full[SCALE_W-2:0];
      bit_cnt <= bit_cnt - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= diff_a * scl_s;
    end
  end

  always_ff @(posedge clk) begin
    if (do_exec) begin
      clamped <= 1'b0;
      if (req.req_type == REQ_APPLY && !calibrated_flag) begin
        corr[0] <= req.in_x;
        corr[1] <= req.in_y;
        corr[2] <= req.in_z;
      end else begin
        for (int i = 0; i < AXES; i++) corr[i] <= '0;
      end
    end else if (sat_en) begin
      corr[axis] <= q_sat;
      if (q_ovf) clamped <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.out_x         <= corr[0];
      result.out_y         <= corr[1];
      result.out_z         <= corr[2];
      result.is_calibrated <= calibrated_flag;
      result.samples_taken <= sample_counter;
      result.saturated     <= clamped;
    end
  end

endmodule

`default_nettype wire

### design/mmc_checker.sv
// Port-level checker for the magnetometer calibrator, bound to the top level.
// Depends on mmc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mmc_checker
  import mmc_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    item_valid,
  input wire logic    item_ready,
  input wire item_t   item,
  input wire logic    result_valid,
  input wire logic    result_ready,
  input wire result_t result
);

  logic any_rail;

  assign any_rail = (result.out_x == 16'sh7FFF) || (result.out_x == 16'sh8000) ||
                    (result.out_y == 16'sh7FFF) || (result.out_y == 16'sh8000) ||
                    (result.out_z == 16'sh7FFF) || (result.out_z == 16'sh8000);

  `MMC_ASSERT_NEXT(a_res_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(result), "stalled result beat changed")
  `MMC_ASSERT_NEXT(a_busy_after_accept, clk, rst, item_valid && item_ready, !item_ready, "request accepted while previous one in flight")
  `MMC_ASSERT(a_sat_needs_cal, clk, rst, !(result_valid && result.saturated && !result.is_calibrated), "clamp flagged on uncalibrated result")
  `MMC_ASSERT(a_sat_on_rail, clk, rst, !(result_valid && result.saturated) || any_rail, "clamp flagged with no axis at a rail")

endmodule

bind magnetometer_minmax_calibrator mmc_checker u_mmc_checker (.*);

`default_nettype wire

### tb/magnetometer_checker.sv
// Result checker for the magnetometer min/max calibrator: watches both channels,
// predicts each result beat from its own calibration state and compares it.
// Depends on mmc_pkg.
`timescale 1ns / 1ps

module magnetometer_checker
  import mmc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  logic    item_ready,
  input  item_t   item,
  input  logic    result_valid,
  input  logic    result_ready,
  input  result_t result,
  output int      errors,
  output int      pending,
  output int      beats_checked,
  output int      corrected_applies,
  output int      clamp_events
);

  logic signed [15:0]  trk_min [AXES];
  logic signed [15:0]  trk_max [AXES];
  logic [CNT_W-1:0]    n_samples;
  logic signed [15:0]  hard_off [AXES];
  logic [SCALE_W-1:0]  soft_gain [AXES];
  logic                calibrated;

  result_t pending_readings [$];
  result_t want;

  task automatic flag_miss(string field, longint wanted, longint got);
    errors++;
    if (errors <= 10) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, wanted, got);
    end
  endtask

  function automatic result_t calibrate_step(item_t it);
    result_t r;
    logic signed [15:0] raw [AXES];
    logic signed [15:0] corr [AXES];
    logic clamped;
    int sum;
    int span;
    longint d;
    longint q;
    r = '0;
    clamped = 1'b0;
    raw[0] = it.in_x;
    raw[1] = it.in_y;
    raw[2] = it.in_z;
    for (int i = 0; i < AXES; i++) corr[i] = '0;
    case (it.req_type)
      REQ_START: begin
        calibrated = 1'b0;
        n_samples = '0;
        for (int i = 0; i < AXES; i++) begin
          trk_min[i] = '0;
          trk_max[i] = '0;
        end
      end
      REQ_SAMPLE: begin
        if (n_samples < SAMPLE_LIMIT_DEF && n_samples < COUNT_CAP) begin
          for (int i = 0; i < AXES; i++) begin
            if (n_samples == 0) begin
              trk_min[i] = raw[i];
              trk_max[i] = raw[i];
            end else begin
              if (raw[i] < trk_min[i]) trk_min[i] = raw[i];
              if (raw[i] > trk_max[i]) trk_max[i] = raw[i];
            end
          end
          n_samples++;
        end
      end
      REQ_FINISH: begin
        for (int i = 0; i < AXES; i++) begin
          sum = int'(trk_max[i]) + int'(trk_min[i]);
          span = int'(trk_max[i]) - int'(trk_min[i]);
          hard_off[i] = 16'(sum >>> 1);
          soft_gain[i] = (span > 0) ? SCALE_W'(int'(UNITY_SCALE) / span) : UNITY_SCALE;
        end
        calibrated = 1'b1;
      end
      REQ_APPLY: begin
        for (int i = 0; i < AXES; i++) begin
          if (calibrated) begin
            d = longint'(raw[i]) - longint'(hard_off[i]);
            q = (d * longint'(soft_gain[i])) >>> FRAC_SHIFT;
            if (q > 32767) begin
              corr[i] = 16'sd32767;
              clamped = 1'b1;
            end else if (q < -32768) begin
              corr[i] = -16'sd32768;
              clamped = 1'b1;
            end else begin
              corr[i] = 16'(q);
            end
          end else begin
            corr[i] = raw[i];
          end
        end
      end
      default: ;
    endcase
    r.out_x = corr[0];
    r.out_y = corr[1];
    r.out_z = corr[2];
    r.is_calibrated = calibrated;
    r.samples_taken = n_samples;
    r.saturated = clamped;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      calibrated = 1'b0;
      n_samples = '0;
      for (int i = 0; i < AXES; i++) begin
        trk_min[i] = '0;
        trk_max[i] = '0;
        hard_off[i] = '0;
        soft_gain[i] = UNITY_SCALE;
      end
      pending_readings.delete();
    end else begin
      if (result_valid && result_ready) begin
        beats_checked++;
        if (pending_readings.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: result beat with nothing outstanding", $realtime);
          end
        end else begin
          want = pending_readings.pop_front();
          if (result.out_x !== want.out_x) flag_miss("out_x", want.out_x, result.out_x);
          if (result.out_y !== want.out_y) flag_miss("out_y", want.out_y, result.out_y);
          if (result.out_z !== want.out_z) flag_miss("out_z", want.out_z, result.out_z);
          if (result.is_calibrated !== want.is_calibrated) begin
            flag_miss("is_calibrated", want.is_calibrated, result.is_calibrated);
          end
          if (result.samples_taken !== want.samples_taken) begin
            flag_miss("samples_taken", want.samples_taken, result.samples_taken);
          end
          if (result.saturated !== want.saturated) begin
            flag_miss("saturated", want.saturated, result.saturated);
          end
        end
      end
      if (item_valid && item_ready) begin
        want = calibrate_step(item);
        if (item.req_type == REQ_APPLY && calibrated) corrected_applies++;
        if (want.saturated) clamp_events++;
        pending_readings.push_back(want);
      end
    end
    pending = pending_readings.size();
  end

endmodule

### tb/testbench.sv
// Top of the calibrator testbench: clock, reset, request stimulus, result back-pressure,
// watchdog and verdict. Depends on mmc_pkg, magnetometer_checker and the calibrator RTL.
`timescale 1ns / 1ps

module testbench;
  import mmc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int RANDOM_ITEMS   = 475;

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_ready;
  item_t   item;
  logic    result_valid;
  logic    result_ready;
  result_t result;

  int errors;
  int pending;
  int beats_checked;
  int corrected_applies;
  int clamp_events;
  int idle_cycles = 0;
  int items_sent = 0;
  int req_count [4] = '{0, 0, 0, 0};
  bit steady = 1'b0;

  magnetometer_minmax_calibrator DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  magnetometer_checker calib_monitor (
    .clk               (clk),
    .rst               (rst),
    .item_valid        (item_valid),
    .item_ready        (item_ready),
    .item              (item),
    .result_valid      (result_valid),
    .result_ready      (result_ready),
    .result            (result),
    .errors            (errors),
    .pending           (pending),
    .beats_checked     (beats_checked),
    .corrected_applies (corrected_applies),
    .clamp_events      (clamp_events)
  );

  always #5 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [15:0] around(int centre, int spread);
    int v;
    v = centre - spread + int'($urandom_range(0, 2 * spread));
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  function automatic logic signed [15:0] any16();
    return 16'($urandom);
  endfunction

  task automatic send(req_t r, logic signed [15:0] x, logic signed [15:0] y,
                      logic signed [15:0] z);
    item_t it;
    int gap;
    it.req_type = r;
    it.in_x = x;
    it.in_y = y;
    it.in_z = z;
    gap = gap_len();
    if (gap > 0) begin
      @(negedge clk);
      item_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (!item_ready);
    items_sent++;
    req_count[int'(r)]++;
  endtask

  // start, a run of samples around a random centre, usually finish, sometimes late samples, then applies
  task automatic run_session();
    int centre [AXES];
    int spread [AXES];
    int n;
    int sel;
    logic signed [15:0] v [AXES];
    steady = ($urandom_range(0, 3) == 0);
    send(REQ_START, any16(), any16(), any16());
    for (int i = 0; i < AXES; i++) begin
      centre[i] = int'($urandom_range(0, 40000)) - 20000;
      sel = $urandom_range(0, 9);
      spread[i] = (sel == 0) ? 0 : (sel < 4) ? $urandom_range(1, 200) : $urandom_range(200, 30000);
    end
    sel = $urandom_range(0, 19);
    n = (sel < 2) ? 0 : (sel == 2) ? 40 : $urandom_range(1, 20);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 19) == 0) begin
        send(req_t'($urandom_range(1, 3)), any16(), any16(), any16());
      end
      for (int i = 0; i < AXES; i++) v[i] = around(centre[i], spread[i]);
      send(REQ_SAMPLE, v[0], v[1], v[2]);
    end
    if ($urandom_range(0, 9) != 0) begin
      send(REQ_FINISH, any16(), any16(), any16());
      if ($urandom_range(0, 9) == 0) send(REQ_FINISH, any16(), any16(), any16());
    end
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        for (int i = 0; i < AXES; i++) v[i] = around(centre[i], spread[i] + 500);
        send(REQ_SAMPLE, v[0], v[1], v[2]);
      end
      if ($urandom_range(0, 1) == 0) send(REQ_FINISH, any16(), any16(), any16());
    end
    repeat ($urandom_range(1, 8)) begin
      if ($urandom_range(0, 4) == 0) begin
        for (int i = 0; i < AXES; i++) v[i] = any16();
      end else begin
        for (int i = 0; i < AXES; i++) v[i] = around(centre[i], spread[i] + spread[i] / 4 + 2);
      end
      send(REQ_APPLY, v[0], v[1], v[2]);
    end
  endtask

  initial begin
    int stall;
    stall = 0;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        result_ready <= 1'b0;
        stall--;
      end else begin
        result_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = gap_len();
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no beat on either channel for %0d cycles", WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int base;
    clk = 1'b0;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // uncalibrated passthrough, then finish straight after reset
    send(REQ_APPLY, -16'sd32768, 16'sd32767, 16'sd0);
    send(REQ_APPLY, 16'h5555, 16'hAAAA, -16'sd1);
    send(REQ_FINISH, 16'sd0, 16'sd0, 16'sd0);
    send(REQ_APPLY, 16'sd0, 16'sd1, -16'sd1);
    send(REQ_APPLY, -16'sd32768, 16'sd32767, 16'sd0);
    send(REQ_START, 16'h7FFF, 16'h8000, 16'hFFFF);
    send(REQ_APPLY, 16'sd100, 16'sd200, 16'sd300);
    send(REQ_FINISH, 16'sd0, 16'sd0, 16'sd0);
    // full-scale span on x and y, zero span on z
    send(REQ_START, 16'sd0, 16'sd0, 16'sd0);
    send(REQ_SAMPLE, -16'sd32768, 16'sd32767, 16'sd7);
    send(REQ_SAMPLE, 16'sd32767, -16'sd32768, 16'sd7);
    send(REQ_SAMPLE, 16'sd0, 16'sd0, 16'sd7);
    send(REQ_FINISH, 16'sd0, 16'sd0, 16'sd0);
    send(REQ_APPLY, -16'sd32768, 16'sd32767, 16'sd7);
    send(REQ_APPLY, 16'sd32767, -16'sd32768, 16'sd8);
    send(REQ_APPLY, 16'sd0, -16'sd1, 16'sd6);
    send(REQ_SAMPLE, 16'sd100, 16'sd100, 16'sd9);
    send(REQ_FINISH, 16'sd0, 16'sd0, 16'sd0);
    send(REQ_APPLY, 16'sd1000, -16'sd1000, 16'sd8);
    // single sample: zero span everywhere
    send(REQ_START, 16'sd0, 16'sd0, 16'sd0);
    send(REQ_SAMPLE, 16'sd1234, -16'sd4321, 16'sd0);
    send(REQ_FINISH, 16'sd0, 16'sd0, 16'sd0);
    send(REQ_APPLY, 16'sd1234, -16'sd4321, 16'sd0);
    send(REQ_APPLY, 16'sd1235, -16'sd4322, 16'sd1);

    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) run_session();
    steady = 1'b0;

    @(negedge clk);
    item_valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests: %0d start, %0d sample, %0d finish, %0d apply",
             items_sent, req_count[0], req_count[1], req_count[2], req_count[3]);
    $display("Checked %0d result beats, %0d corrected applies, %0d with clamping, %0d errors",
             beats_checked, corrected_applies, clamp_events, errors);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/mmc_pkg.sv
design/magnetometer_minmax_calibrator.sv
design/mmc_checker.sv
tb/magnetometer_checker.sv
tb/testbench.sv
